// ===== sv/tclb_pkg.sv =====
// tclb_pkg: shared types and constants for the tab compressing line buffer.
// Used by every module of the block; depends on nothing.
package tclb_pkg;

	localparam int LINE_SIZE   = 64;
	localparam int STORE_DEPTH = 64;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int POS_W       = ADDR_W + 1;

	localparam logic [POS_W-1:0] FLUSH_AT  = POS_W'(LINE_SIZE - 9);
	localparam logic [POS_W-1:0] STORE_END = POS_W'(STORE_DEPTH);

	localparam logic [7:0] CH_NUL = 8'd0;
	localparam logic [7:0] CH_TAB = 8'd9;
	localparam logic [7:0] CH_NL  = 8'd10;
	localparam logic [7:0] CH_SP  = 8'd32;

	typedef struct packed {
		logic [7:0] ch;
		logic       suppress;
	} req_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last;
	} res_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [7:0]        wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} store_req_t;

	typedef struct packed {
		logic valid;
		res_t data;
	} emit_t;

endpackage

// ===== sv/tab_compressing_line_buffer_core.sv =====
// Tab compressing line buffer, top level: sequencer, line store and output register.
// Depends on tclb_pkg, tclb_ctrl, tclb_store, tclb_obuf.
//
// Console characters are collected in a 64-entry line store; a tab expands to
// spaces up to the next column multiple of 8, nulls and suppressed requests are
// dropped. A newline flushes the line with runs of spaces that reach a tab stop
// turned back into tabs and trailing spaces removed, ending in a newline marked
// last. Reaching 55 buffered characters flushes the line raw, last on the final
// character. The block takes one request at a time and holds req_stall high
// while it works: a plain character is written, then the fill is checked; a
// tab writes one space per step, then the same check; a suppressed request or
// null leaves it idle. A newline reads each buffered character; a space adds to
// the pending run, another character first emits pending tabs and spaces. A raw
// flush reads, then emits, each buffered character. The store is walked through
// the shared position counter; any res_stall stretches the emitting states.
// No clearing pass after reset.
module tab_compressing_line_buffer_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  tclb_pkg::req_t   req_data,
	output logic             res_valid,
	input  logic             res_stall,
	output tclb_pkg::res_t   res_data
);

	tclb_pkg::store_req_t mem;
	tclb_pkg::emit_t      emit;
	logic [7:0]           rdata;
	logic                 emit_free;

	tclb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_data  (req_data),
		.req_stall (req_stall),
		.emit_free (emit_free),
		.emit      (emit),
		.mem       (mem),
		.rdata     (rdata)
	);

	tclb_store u_store (
		.clk   (clk),
		.mem   (mem),
		.rdata (rdata)
	);

	tclb_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.emit      (emit),
		.emit_free (emit_free),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule

// ===== sv/tclb_store.sv =====
// tclb_store: line store, one write and one registered read per cycle.
// Depends on tclb_pkg.
module tclb_store (
	input  logic                           clk,
	input  tclb_pkg::store_req_t           mem,
	output logic [7:0]                     rdata
);

	logic [7:0] line_q [tclb_pkg::STORE_DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (mem.we) begin
			line_q[mem.waddr] <= mem.wdata;
		end
		if (mem.re) begin
			rdata_q <= line_q[mem.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/tclb_obuf.sv =====
// tclb_obuf: result output register between the sequencer and the result channel.
// Depends on tclb_pkg.
module tclb_obuf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tclb_pkg::emit_t      emit,
	output logic                 emit_free,
	output logic                 res_valid,
	input  logic                 res_stall,
	output tclb_pkg::res_t       res_data
);

	logic           valid_q;
	tclb_pkg::res_t data_q;

	assign emit_free = !valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (emit_free) begin
			valid_q <= emit.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_free && emit.valid) begin
			data_q <= emit.data;
		end
	end

	assign res_valid = valid_q;
	assign res_data  = data_q;

endmodule

// ===== sv/tclb_ctrl.sv =====
// tclb_ctrl: sequencer with the shared position step unit; fills, flushes
// and tab-compresses the line store. Depends on tclb_pkg.
module tclb_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	input  tclb_pkg::req_t         req_data,
	output logic                   req_stall,
	input  logic                   emit_free,
	output tclb_pkg::emit_t        emit,
	output tclb_pkg::store_req_t   mem,
	input  logic [7:0]             rdata
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_TABW   = 4'd1;
	localparam logic [3:0] S_CHK    = 4'd2;
	localparam logic [3:0] S_RAW_RD = 4'd3;
	localparam logic [3:0] S_RAW_EM = 4'd4;
	localparam logic [3:0] S_C_RD   = 4'd5;
	localparam logic [3:0] S_C_EV   = 4'd6;
	localparam logic [3:0] S_C_TAB  = 4'd7;
	localparam logic [3:0] S_C_SP   = 4'd8;
	localparam logic [3:0] S_NL     = 4'd9;

	localparam int PW = tclb_pkg::POS_W;
	localparam int AW = tclb_pkg::ADDR_W;

	logic [3:0]    state_q, state_d;
	logic [PW-1:0] fill_q, fill_d;
	logic [PW-1:0] pos_q, pos_d;
	logic [2:0]    tabs_q, tabs_d;
	logic [3:0]    run_q, run_d;
	logic [7:0]    dch_q, dch_d;

	// shared step unit
	logic [PW-1:0] inc_a, inc_y;
	logic          inc_eq_fill, inc_nb;
	logic          accept, boundary;
	logic [2:0]    eff_tabs;
	logic [3:0]    eff_run;

	assign inc_a       = (state_q == S_IDLE || state_q == S_TABW) ? fill_q : pos_q;
	assign inc_y       = PW'(inc_a + PW'(1));
	assign inc_eq_fill = (inc_y == fill_q);
	assign inc_nb      = (inc_y[2:0] == 3'd0) || (inc_y >= tclb_pkg::STORE_END);

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && (state_q == S_IDLE);

	// a run of spaces that reaches a column multiple of 8 becomes a tab
	assign boundary = (pos_q[2:0] == 3'd0) && (run_q != 4'd0);
	assign eff_tabs = boundary ? 3'(tabs_q + 3'd1) : tabs_q;
	assign eff_run  = boundary ? 4'd0 : run_q;

	always_comb begin
		state_d = state_q;
		fill_d  = fill_q;
		pos_d   = pos_q;
		tabs_d  = tabs_q;
		run_d   = run_q;
		dch_d   = dch_q;
		mem     = '0;
		emit    = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && !req_data.suppress) begin
					priority if (req_data.ch == tclb_pkg::CH_NL) begin
						pos_d  = '0;
						tabs_d = '0;
						run_d  = '0;
						state_d = (fill_q == '0) ? S_NL : S_C_RD;
					end else if (req_data.ch == tclb_pkg::CH_TAB) begin
						state_d = S_TABW;
					end else if (req_data.ch != tclb_pkg::CH_NUL) begin
						mem.we    = 1'b1;
						mem.waddr = fill_q[AW-1:0];
						mem.wdata = req_data.ch;
						fill_d    = inc_y;
						state_d   = S_CHK;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_TABW: begin
				mem.we    = 1'b1;
				mem.waddr = fill_q[AW-1:0];
				mem.wdata = tclb_pkg::CH_SP;
				fill_d    = inc_y;
				if (inc_nb) begin
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				pos_d   = '0;
				state_d = (fill_q >= tclb_pkg::FLUSH_AT) ? S_RAW_RD : S_IDLE;
			end
			S_RAW_RD: begin
				mem.re    = 1'b1;
				mem.raddr = pos_q[AW-1:0];
				state_d   = S_RAW_EM;
			end
			S_RAW_EM: begin
				if (emit_free) begin
					emit.valid         = 1'b1;
					emit.data.out_char = rdata;
					emit.data.last     = inc_eq_fill;
					pos_d              = inc_y;
					if (inc_eq_fill) begin
						fill_d  = '0;
						state_d = S_IDLE;
					end else begin
						state_d = S_RAW_RD;
					end
				end
			end
			S_C_RD: begin
				mem.re    = 1'b1;
				mem.raddr = pos_q[AW-1:0];
				state_d   = S_C_EV;
			end
			S_C_EV: begin
				tabs_d = eff_tabs;
				if (rdata == tclb_pkg::CH_SP) begin
					run_d   = 4'(eff_run + 4'd1);
					pos_d   = inc_y;
					state_d = inc_eq_fill ? S_NL : S_C_RD;
				end else begin
					run_d   = eff_run;
					dch_d   = rdata;
					state_d = S_C_TAB;
				end
			end
			S_C_TAB: begin
				if (tabs_q != 3'd0) begin
					if (emit_free) begin
						emit.valid         = 1'b1;
						emit.data.out_char = tclb_pkg::CH_TAB;
						tabs_d             = 3'(tabs_q - 3'd1);
					end
				end else begin
					state_d = S_C_SP;
				end
			end
			S_C_SP: begin
				if (emit_free) begin
					emit.valid = 1'b1;
					if (run_q != 4'd0) begin
						emit.data.out_char = tclb_pkg::CH_SP;
						run_d              = 4'(run_q - 4'd1);
					end else begin
						emit.data.out_char = dch_q;
						pos_d              = inc_y;
						state_d            = inc_eq_fill ? S_NL : S_C_RD;
					end
				end
			end
			S_NL: begin
				if (emit_free) begin
					emit.valid         = 1'b1;
					emit.data.out_char = tclb_pkg::CH_NL;
					emit.data.last     = 1'b1;
					fill_d             = '0;
					state_d            = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			pos_q   <= '0;
			tabs_q  <= '0;
			run_q   <= '0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			pos_q   <= pos_d;
			tabs_q  <= tabs_d;
			run_q   <= run_d;
		end
	end

	always_ff @(posedge clk) begin
		dch_q <= dch_d;
	end

endmodule

// ===== sv/tclb_checker.sv =====
// tclb_checker: port-level assertions for the line buffer, bound to the top level.
// Depends on tclb_pkg and tab_compressing_line_buffer_core.
module tclb_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_stall,
	input tclb_pkg::req_t   req_data,
	input logic             res_valid,
	input logic             res_stall,
	input tclb_pkg::res_t   res_data
);

	// stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_data))
		else $error("stalled result changed");

	// dropped request leaves block ready
	a_suppress_ready: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && (req_data.suppress || req_data.ch == tclb_pkg::CH_NUL)
		|=> !req_stall)
		else $error("dropped request made block busy");

	// newline always starts a flush
	a_nl_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && !req_data.suppress && req_data.ch == tclb_pkg::CH_NL
		|=> req_stall)
		else $error("newline did not start flush");

	// mid-flush result implies busy
	a_mid_flush_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.last |-> req_stall)
		else $error("ready during flush");

endmodule

bind tab_compressing_line_buffer_core tclb_checker u_tclb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req_data  (req_data),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_data  (res_data)
);
